### hw/rtl/tws_pkg.sv
// Package for the text word slot tokenizer: geometry constants, state and
// result types, the character encoder and the punctuation test.
// No dependencies; used by every module of the block.
package tws_pkg;

	localparam int CHARS_PER_WORD  = 16;
	localparam int WORDS_PER_FRAME = 32;

	localparam logic [6:0] CODE_NL_KEEP   = 7'd95;
	localparam logic [6:0] CODE_NL_FOLD   = 7'd69;
	localparam logic [6:0] CODE_MAX_KEEP  = 7'd96;
	localparam logic [6:0] CODE_MAX_FOLD  = 7'd70;
	localparam logic [7:0] BYTE_LF        = 8'd10;
	localparam logic [7:0] BYTE_CR        = 8'd13;
	localparam logic [7:0] BYTE_SPACE     = 8'd32;
	localparam logic [7:0] BYTE_LOWER_A   = 8'd97;
	localparam logic [7:0] BYTE_FOLD_OFS  = 8'd64;

	localparam logic [0:0] REG_KEEP_CAPITALS = 1'd0;

	typedef enum logic [1:0] {
		MODE_SKIP = 2'd0,
		MODE_WORD = 2'd1,
		MODE_DROP = 2'd2
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [4:0] chars;
		logic [4:0] slot;
	} tok_state_t;

	typedef struct packed {
		logic [4:0] word_slot;
		logic [4:0] char_position;
		logic [6:0] char_code;
		logic       has_char;
		logic       closes_word;
		logic       closes_frame;
		logic       last_result;
	} result_t;

	function automatic logic [6:0] encode_byte(input logic [7:0] b, input logic keep);
		logic [7:0] v;
		logic [6:0] code;
		if (b == BYTE_LF || b == BYTE_CR) begin
			code = keep ? CODE_NL_KEEP : CODE_NL_FOLD;
		end else if (b < BYTE_SPACE) begin
			code = keep ? CODE_MAX_KEEP : CODE_MAX_FOLD;
		end else if (keep) begin
			v = b - BYTE_SPACE;
			code = (v > {1'b0, CODE_MAX_KEEP}) ? CODE_MAX_KEEP : v[6:0];
		end else begin
			v = (b < BYTE_LOWER_A) ? b - BYTE_SPACE : b - BYTE_FOLD_OFS;
			code = (v > {1'b0, CODE_MAX_FOLD}) ? CODE_MAX_FOLD : v[6:0];
		end
		return code;
	endfunction

	function automatic logic is_punct(input logic [6:0] c, input logic keep);
		logic p;
		p = c inside {7'd1, 7'd2, 7'd8, 7'd9, 7'd12, 7'd13, 7'd14,
			7'd26, 7'd27, 7'd28, 7'd31, 7'd32, 7'd64};
		return p || (c == (keep ? CODE_NL_KEEP : CODE_NL_FOLD));
	endfunction

	// slot after a close, wrapping at the frame end
	function automatic logic [4:0] next_slot(input logic [4:0] s);
		logic [5:0] n;
		n = {1'b0, s} + 6'd1;
		return (n >= 6'(WORDS_PER_FRAME)) ? 5'd0 : n[4:0];
	endfunction

	function automatic logic frame_end(input logic [4:0] s);
		return ({1'b0, s} + 6'd1) >= 6'(WORDS_PER_FRAME);
	endfunction

endpackage

### hw/rtl/tws_cfg.sv
// APB-style configuration register file: holds keep_capitals.
// Depends on tws_pkg for the register index.
module tws_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        keep_caps
);

	logic keep_q;
	logic hit;

	assign hit = (paddr[2:2] == tws_pkg::REG_KEEP_CAPITALS) && (paddr[1:0] == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b1;
		end else if (psel && penable && pwrite && hit) begin
			keep_q <= pwdata[0];
		end
	end

	assign pready    = 1'b1;
	assign prdata    = hit ? {31'd0, keep_q} : 32'd0;
	assign keep_caps = keep_q;

endmodule

### hw/rtl/tws_core.sv
// Combinational tokenizer step: encodes one byte and, from the current word
// state, forms up to two results and the next state. Depends on tws_pkg.
module tws_core (
	input  logic                byte_in,
	input  logic [7:0]          text_byte,
	input  logic                keep_caps,
	input  tws_pkg::tok_state_t cur_state,
	output tws_pkg::tok_state_t next_state,
	output tws_pkg::result_t    res0,
	output tws_pkg::result_t    res1,
	output logic [1:0]          res_count
);

	logic [6:0] code;
	logic       space;
	logic       punct;
	logic [5:0] pos_inc;
	logic       full;
	logic [4:0] slot_n;
	logic [4:0] letter_pos;

	assign code  = tws_pkg::encode_byte(text_byte, keep_caps);
	assign space = (code == 7'd0);
	assign punct = !space && tws_pkg::is_punct(code, keep_caps);
	assign slot_n = tws_pkg::next_slot(cur_state.slot);

	always_comb begin
		next_state = cur_state;
		res0       = '0;
		res1       = '0;
		res_count  = 2'd0;
		letter_pos = (cur_state.mode == tws_pkg::MODE_WORD) ? cur_state.chars : 5'd0;
		pos_inc    = {1'b0, letter_pos} + 6'd1;
		full       = pos_inc >= 6'(tws_pkg::CHARS_PER_WORD);

		if (byte_in) begin
			case (cur_state.mode)
				tws_pkg::MODE_WORD: begin
					if (space || punct) begin
						// close marker carrying the word length
						res0.word_slot     = cur_state.slot;
						res0.char_position = cur_state.chars;
						res0.closes_word   = 1'b1;
						res0.closes_frame  = tws_pkg::frame_end(cur_state.slot);
						next_state.mode    = tws_pkg::MODE_SKIP;
						next_state.chars   = 5'd0;
						next_state.slot    = slot_n;
						res_count          = 2'd1;
						if (punct) begin
							res1.word_slot    = slot_n;
							res1.char_code    = code;
							res1.has_char     = 1'b1;
							res1.closes_word  = 1'b1;
							res1.closes_frame = tws_pkg::frame_end(slot_n);
							next_state.slot   = tws_pkg::next_slot(slot_n);
							res_count         = 2'd2;
						end
					end
				end
				tws_pkg::MODE_DROP: begin
					if (space) begin
						next_state.mode = tws_pkg::MODE_SKIP;
					end else if (punct) begin
						next_state.mode = tws_pkg::MODE_SKIP;
					end
				end
				default: begin
					next_state.mode  = tws_pkg::MODE_SKIP;
					next_state.chars = 5'd0;
				end
			endcase

			// single-character punctuation word outside a word
			if (punct && cur_state.mode != tws_pkg::MODE_WORD) begin
				res0.word_slot    = cur_state.slot;
				res0.char_code    = code;
				res0.has_char     = 1'b1;
				res0.closes_word  = 1'b1;
				res0.closes_frame = tws_pkg::frame_end(cur_state.slot);
				next_state.chars  = 5'd0;
				next_state.slot   = slot_n;
				res_count         = 2'd1;
			end

			// store a letter, closing the word when it fills the last position
			if (!space && !punct && cur_state.mode != tws_pkg::MODE_DROP) begin
				res0.word_slot     = cur_state.slot;
				res0.char_position = letter_pos;
				res0.char_code     = code;
				res0.has_char      = 1'b1;
				res_count          = 2'd1;
				if (full) begin
					res0.closes_word  = 1'b1;
					res0.closes_frame = tws_pkg::frame_end(cur_state.slot);
					next_state.mode   = tws_pkg::MODE_DROP;
					next_state.chars  = 5'd0;
					next_state.slot   = slot_n;
				end else begin
					next_state.mode  = tws_pkg::MODE_WORD;
					next_state.chars = pos_inc[4:0];
				end
			end
		end

		res0.last_result = (res_count == 2'd1);
		res1.last_result = 1'b1;
	end

endmodule

### hw/rtl/text_word_slot_tokenizer_unit.sv
// Text word slot tokenizer top level: input register, tokenizer step,
// result register with a hold slot for a second result.
// Depends on tws_pkg, tws_cfg and tws_core.
//
// Usage:
//   Input channel (in_valid, in_stall, text_byte) takes one text byte per
//   transaction. Output channel (out_valid, out_stall and the result fields)
//   delivers stored characters and word-close markers in stream order.
//   A byte is captured in the input register; its result loads into the
//   result register when the output is free and the hold slot is empty.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and the receiver does not stall. A byte that gives two results
//   (punctuation inside a word) holds the next byte in the input register
//   while the hold slot drains. Spaces between words give no result.
//   When the receiver stalls, the result register and the input register
//   hold; in_stall rises once the input register is full and blocked.
//   Reset clears all valids, sets keep_capitals to 1 and the word state to
//   between words, slot 0. The APB port writes keep_capitals at byte
//   address 0; write it only while the block is idle.
module text_word_slot_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  word_slot,
	output logic [4:0]  char_position,
	output logic [6:0]  char_code,
	output logic        has_char,
	output logic        closes_word,
	output logic        closes_frame,
	output logic        last_result
);

	logic                keep_caps;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	tws_pkg::tok_state_t state_q;
	tws_pkg::tok_state_t state_next;
	tws_pkg::result_t    res0;
	tws_pkg::result_t    res1;
	logic [1:0]          res_count;
	tws_pkg::result_t    out_q;
	logic                out_valid_q;
	tws_pkg::result_t    hold_q;
	logic                hold_valid_q;
	logic                out_free;
	logic                consume;
	logic                in_accept;

	tws_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.keep_caps (keep_caps)
	);

	tws_core u_core (
		.byte_in    (consume),
		.text_byte  (byte_s1),
		.keep_caps  (keep_caps),
		.cur_state  (state_q),
		.next_state (state_next),
		.res0       (res0),
		.res1       (res1),
		.res_count  (res_count)
	);

	assign out_free  = !out_valid_q || !out_stall;
	// the second result drains before the next byte is worked on
	assign consume   = valid_s1 && out_free && !hold_valid_q;
	assign in_stall  = valid_s1 && !consume;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !consume);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= tws_pkg::MODE_SKIP;
			state_q.chars <= 5'd0;
			state_q.slot  <= 5'd0;
		end else if (consume) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (out_free) begin
			if (hold_valid_q) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
			end else if (consume) begin
				out_valid_q  <= (res_count != 2'd0);
				hold_valid_q <= (res_count == 2'd2);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_valid_q) begin
				out_q <= hold_q;
			end else if (consume) begin
				out_q  <= res0;
				hold_q <= res1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign word_slot     = out_q.word_slot;
	assign char_position = out_q.char_position;
	assign char_code     = out_q.char_code;
	assign has_char      = out_q.has_char;
	assign closes_word   = out_q.closes_word;
	assign closes_frame  = out_q.closes_frame;
	assign last_result   = out_q.last_result;

endmodule

### dv/tws_token_checker.sv
// Token checker for the text word slot tokenizer: watches the APB port and both
// channels, predicts every result from accepted text bytes and compares them.
// Depends on tws_pkg for the result type, state enum and frame geometry.
`timescale 1ns / 1ps

module tws_token_checker import tws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  word_slot,
	input  logic [4:0]  char_position,
	input  logic [6:0]  char_code,
	input  logic        has_char,
	input  logic        closes_word,
	input  logic        closes_frame,
	input  logic        last_result,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          frames
);

	localparam logic [2:0] KEEP_CAPS_ADDR = {REG_KEEP_CAPITALS, 2'b00};

	logic       keep_caps;
	mode_t      tok_mode;
	logic [4:0] tok_len;
	logic [4:0] tok_slot;
	result_t    expected_tokens[$];
	result_t    byte_tokens[$];

	function automatic logic [6:0] code_for_byte(input logic [7:0] b);
		int v;
		if (b == BYTE_LF || b == BYTE_CR)
			return keep_caps ? CODE_NL_KEEP : CODE_NL_FOLD;
		if (b < BYTE_SPACE)
			return keep_caps ? CODE_MAX_KEEP : CODE_MAX_FOLD;
		if (keep_caps) begin
			v = int'(b) - 32;
			return (v > int'(CODE_MAX_KEEP)) ? CODE_MAX_KEEP : 7'(v);
		end
		v = (b < BYTE_LOWER_A) ? int'(b) - 32 : int'(b) - 64;
		return (v > int'(CODE_MAX_FOLD)) ? CODE_MAX_FOLD : 7'(v);
	endfunction

	// punctuation codes form a word of their own
	function automatic logic is_mark(input logic [6:0] c);
		case (c)
			7'd1, 7'd2, 7'd8, 7'd9, 7'd12, 7'd13, 7'd14,
			7'd26, 7'd27, 7'd28, 7'd31, 7'd32, 7'd64: return 1'b1;
			default: return c == (keep_caps ? CODE_NL_KEEP : CODE_NL_FOLD);
		endcase
	endfunction

	task automatic push_token(input logic [4:0] pos, input logic [6:0] code,
			input logic has, input logic closes);
		result_t r;
		r.word_slot     = tok_slot;
		r.char_position = pos;
		r.char_code     = code;
		r.has_char      = has;
		r.closes_word   = closes;
		r.closes_frame  = closes && (int'(tok_slot) + 1 >= WORDS_PER_FRAME);
		r.last_result   = 1'b0;
		byte_tokens.push_back(r);
		if (closes) begin
			tok_slot = r.closes_frame ? 5'd0 : tok_slot + 5'd1;
			tok_len  = 5'd0;
		end
	endtask

	task automatic add_letter(input logic [6:0] code);
		if (int'(tok_len) + 1 >= CHARS_PER_WORD) begin
			push_token(tok_len, code, 1'b1, 1'b1);
			tok_mode = MODE_DROP;
		end else begin
			push_token(tok_len, code, 1'b1, 1'b0);
			tok_len  = tok_len + 5'd1;
			tok_mode = MODE_WORD;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [6:0] code;
		logic       blank;
		logic       mark;
		result_t    r;
		code  = code_for_byte(b);
		blank = (code == 7'd0);
		mark  = !blank && is_mark(code);
		byte_tokens.delete();
		case (tok_mode)
			MODE_WORD: begin
				if (blank) begin
					push_token(tok_len, 7'd0, 1'b0, 1'b1);
					tok_mode = MODE_SKIP;
				end else if (mark) begin
					push_token(tok_len, 7'd0, 1'b0, 1'b1);
					push_token(5'd0, code, 1'b1, 1'b1);
					tok_mode = MODE_SKIP;
				end else begin
					add_letter(code);
				end
			end
			MODE_DROP: begin
				if (blank) begin
					tok_mode = MODE_SKIP;
				end else if (mark) begin
					push_token(5'd0, code, 1'b1, 1'b1);
					tok_mode = MODE_SKIP;
				end
			end
			default: begin
				tok_mode = MODE_SKIP;
				tok_len  = 5'd0;
				if (mark)
					push_token(5'd0, code, 1'b1, 1'b1);
				else if (!blank)
					add_letter(code);
			end
		endcase
		for (int i = 0; i < byte_tokens.size(); i++) begin
			r = byte_tokens[i];
			r.last_result = (i == byte_tokens.size() - 1);
			expected_tokens.push_back(r);
		end
	endtask

	task automatic check_field(input string field, input logic [6:0] want,
			input logic [6:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_result();
		result_t want;
		if (expected_tokens.size() == 0) begin
			$error("result with no transaction pending: slot %0d position %0d code %0d",
				word_slot, char_position, char_code);
			fail_count++;
		end else begin
			want = expected_tokens.pop_front();
			check_field("word_slot", 7'(want.word_slot), 7'(word_slot));
			check_field("char_position", 7'(want.char_position), 7'(char_position));
			check_field("char_code", want.char_code, char_code);
			check_field("has_char", 7'(want.has_char), 7'(has_char));
			check_field("closes_word", 7'(want.closes_word), 7'(closes_word));
			check_field("closes_frame", 7'(want.closes_frame), 7'(closes_frame));
			check_field("last_result", 7'(want.last_result), 7'(last_result));
			checked++;
			if (want.closes_frame)
				frames++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_caps  = 1'b1;
			tok_mode   = MODE_SKIP;
			tok_len    = 5'd0;
			tok_slot   = 5'd0;
			expected_tokens.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
			frames     = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == KEEP_CAPS_ADDR)
				keep_caps = pwdata[0];
			if (in_valid && !in_stall)
				predict_byte(text_byte);
			if (out_valid && !out_stall)
				compare_result();
			pending = expected_tokens.size();
		end
	end

endmodule

### dv/testbench.sv
// Top of the tokenizer testbench: clock, reset, APB writes, text byte stimulus
// and receiver stalls; the verdict comes from tws_token_checker.
// Depends on tws_pkg, tws_token_checker and text_word_slot_tokenizer_unit.
`timescale 1ns / 1ps

module testbench;
	import tws_pkg::*;

	localparam logic [2:0] KEEP_CAPS_ADDR = {REG_KEEP_CAPITALS, 2'b00};
	localparam logic [2:0] UNUSED_ADDR    = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  word_slot;
	logic [4:0]  char_position;
	logic [6:0]  char_code;
	logic        has_char;
	logic        closes_word;
	logic        closes_frame;
	logic        last_result;

	int fail_count;
	int pending;
	int checked;
	int frames;
	int bytes_sent = 0;
	int tx_gap_max = 0;
	int rx_stall_max = 0;
	int rx_hold_cycles = 0;

	logic [7:0] mark_bytes[15] = '{8'd33, 8'd34, 8'd40, 8'd41, 8'd44, 8'd45, 8'd46,
		8'd58, 8'd59, 8'd60, 8'd63, 8'd64, 8'd96, 8'd10, 8'd13};

	text_word_slot_tokenizer_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.word_slot(word_slot), .char_position(char_position), .char_code(char_code),
		.has_char(has_char), .closes_word(closes_word), .closes_frame(closes_frame),
		.last_result(last_result)
	);

	tws_token_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .text_byte(text_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.word_slot(word_slot), .char_position(char_position), .char_code(char_code),
		.has_char(has_char), .closes_word(closes_word), .closes_frame(closes_frame),
		.last_result(last_result),
		.fail_count(fail_count), .pending(pending), .checked(checked), .frames(frames)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stall before each result, or one long hold on request
	initial begin : receiver
		int w;
		wait (arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				w = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				w = $urandom_range(0, rx_stall_max);
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [7:0] letter_byte();
		int r;
		r = $urandom_range(0, 61);
		if (r < 26)
			return 8'(65 + r);
		if (r < 52)
			return 8'(97 + r - 26);
		return 8'(48 + r - 52);
	endfunction

	function automatic logic [7:0] mark_byte();
		return mark_bytes[$urandom_range(0, 14)];
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// mostly words of random letters with spaces and punctuation, some noise
	task automatic send_text(input int n);
		int stop_at;
		int len;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0: send_byte(8'($urandom_range(0, 255)));
				1: send_byte(mark_byte());
				default: begin
					len = ($urandom_range(0, 6) == 0) ? $urandom_range(14, 20)
						: $urandom_range(1, 8);
					repeat (len) send_byte(letter_byte());
					if ($urandom_range(0, 3) == 0)
						send_byte(mark_byte());
					repeat ($urandom_range(0, 2)) send_byte(BYTE_SPACE);
				end
			endcase
		end
	endtask

	// wait for every result, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_capitals(input logic keep);
		drain();
		reg_write(KEEP_CAPS_ADDR, ($urandom() & 32'hFFFF_FFFE) | 32'(keep));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// capitals kept after reset: extremes, punctuation inside a word,
		// newline words, a full-length word with a dropped tail
		tx_gap_max   = 2;
		rx_stall_max = 2;
		send_byte(8'd32);
		send_byte(8'd0);
		send_byte(8'd255);
		send_byte(8'd44);
		send_byte(BYTE_LF);
		send_byte(BYTE_CR);
		send_byte(8'd32);
		send_string("Abcdefghijklmnopqr");
		send_byte(8'd33);
		send_byte(8'd120);
		send_byte(8'd127);
		send_byte(8'd32);

		// folded capitals; the write beyond the register list must be ignored
		set_capitals(1'b0);
		reg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
		send_string("a`b");
		send_byte(8'd128);
		send_byte(8'd255);
		send_byte(8'd126);
		send_byte(BYTE_LF);
		send_byte(8'd31);
		send_byte(8'd32);

		tx_gap_max   = 15;
		rx_stall_max = 15;
		send_text(200);

		// hold the receiver while the sender streams, so the input backs up
		set_capitals(1'b1);
		tx_gap_max     = 0;
		rx_stall_max   = 0;
		rx_hold_cycles = 300;
		send_text(60);
		send_text(150);

		set_capitals(1'b0);
		tx_gap_max   = 3;
		rx_stall_max = 3;
		send_text(200);

		set_capitals(1'b1);
		tx_gap_max   = 15;
		rx_stall_max = 4;
		send_text(100);
		tx_gap_max   = 1;
		rx_stall_max = 15;
		send_text(100);

		drain();
		$display("Covered %0d text bytes in both capital modes, %0d results checked.",
			bytes_sent, checked);
		$display("Frame wraps seen: %0d; one long receiver hold and several drains.",
			frames);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
hw/rtl/tws_pkg.sv
hw/rtl/tws_cfg.sv
hw/rtl/tws_core.sv
hw/rtl/text_word_slot_tokenizer_unit.sv
dv/tws_token_checker.sv
dv/testbench.sv
